>>> rtl/assert_macros.svh
// Assertion macros used by the RTL module tfp_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TFP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("telemetry frame packer assertion failed");

`define TFP_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("telemetry frame packer forbidden condition seen");

`else

`define TFP_ASSERT(label, clk, rst_n, prop)

`define TFP_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> rtl/tfp_pkg.sv
package tfp_pkg;

    localparam logic [1:0] CMD_SIX_AXES = 2'd0;
    localparam logic [1:0] CMD_ANGLES   = 2'd1;
    localparam logic [1:0] CMD_QUAT     = 2'd2;
    localparam logic [1:0] CMD_NONE     = 2'd3;

    localparam logic [7:0] HDR_BYTE    = 8'hAA;
    localparam logic [7:0] STATUS_BYTE = 8'h01;
    localparam logic [7:0] DEST_RESET  = 8'hFF;

    localparam logic [7:0] FUNC_SIX_AXES = 8'h01;
    localparam logic [7:0] FUNC_ANGLES   = 8'h03;
    localparam logic [7:0] FUNC_QUAT     = 8'h04;

    localparam logic [7:0] LEN_SIX_AXES = 8'h0D;
    localparam logic [7:0] LEN_ANGLES   = 8'h07;
    localparam logic [7:0] LEN_QUAT     = 8'h09;

    localparam int IDX_W = 5;

    localparam logic [IDX_W-1:0] LAST_SIX_AXES = 5'd18;
    localparam logic [IDX_W-1:0] LAST_ANGLES   = 5'd12;
    localparam logic [IDX_W-1:0] LAST_QUAT     = 5'd14;

    localparam logic [IDX_W-1:0] IDX_HDR     = 5'd0;
    localparam logic [IDX_W-1:0] IDX_DEST    = 5'd1;
    localparam logic [IDX_W-1:0] IDX_FUNC    = 5'd2;
    localparam logic [IDX_W-1:0] IDX_LEN     = 5'd3;
    localparam logic [IDX_W-1:0] IDX_PAYLOAD = 5'd4;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] value_a;
        logic [15:0] value_b;
        logic [15:0] value_c;
        logic [15:0] value_d;
        logic [15:0] value_e;
        logic [15:0] value_f;
    } tfp_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } tfp_out_t;

    typedef struct packed {
        logic [7:0]       func_code;
        logic [7:0]       len_code;
        logic [IDX_W-1:0] last_idx;
        logic [5:0][15:0] values;
    } tfp_job_t;

    function automatic logic [7:0] func_code_of(input logic [1:0] cmd);
        logic [7:0] code;
        unique case (cmd)
            CMD_SIX_AXES: code = FUNC_SIX_AXES;
            CMD_ANGLES:   code = FUNC_ANGLES;
            CMD_QUAT:     code = FUNC_QUAT;
            default:      code = 8'h00;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] len_code_of(input logic [1:0] cmd);
        logic [7:0] len;
        unique case (cmd)
            CMD_SIX_AXES: len = LEN_SIX_AXES;
            CMD_ANGLES:   len = LEN_ANGLES;
            CMD_QUAT:     len = LEN_QUAT;
            default:      len = 8'h00;
        endcase
        return len;
    endfunction

    function automatic logic [IDX_W-1:0] last_idx_of(input logic [1:0] cmd);
        logic [IDX_W-1:0] last;
        unique case (cmd)
            CMD_SIX_AXES: last = LAST_SIX_AXES;
            CMD_ANGLES:   last = LAST_ANGLES;
            CMD_QUAT:     last = LAST_QUAT;
            default:      last = '0;
        endcase
        return last;
    endfunction

endpackage

>>> rtl/tfp_front.sv
module tfp_front import tfp_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tfp_in_t  s_data,
    output logic     head_valid,
    output tfp_job_t head_job,
    input  logic     head_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tfp_job_t         queue_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    tfp_job_t         new_job;

    assign s_ready    = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = queue_reg[rd_ptr_reg];

    // Requests with an undefined frame type are taken and dropped.
    assign push = s_valid && s_ready && (s_data.cmd != CMD_NONE);

    always_comb begin
        new_job.func_code = func_code_of(s_data.cmd);
        new_job.len_code  = len_code_of(s_data.cmd);
        new_job.last_idx  = last_idx_of(s_data.cmd);
        new_job.values[0] = s_data.value_a;
        new_job.values[1] = s_data.value_b;
        new_job.values[2] = s_data.value_c;
        new_job.values[3] = s_data.value_d;
        new_job.values[4] = s_data.value_e;
        new_job.values[5] = s_data.value_f;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (head_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, head_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= new_job;
        end
    end

endmodule

>>> rtl/tfp_back.sv
`include "assert_macros.svh"

module tfp_back import tfp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic [7:0] dest_addr,
    input  logic     head_valid,
    input  tfp_job_t head_job,
    output logic     head_pop,
    output logic     m_valid,
    input  logic     m_ready,
    output tfp_out_t m_data
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       add_reg, add_next;
    logic             m_valid_reg, m_valid_next;
    tfp_out_t         m_data_reg, m_data_next;
    logic             advance;
    logic             is_last;
    logic             is_check;
    logic [7:0]       cur_byte;
    logic [7:0]       payload_byte;
    logic [15:0]      cur_value;
    logic [IDX_W-1:0] pay_idx;
    logic [7:0]       sum_upd;

    assign advance  = head_valid && (!m_valid_reg || m_ready);
    assign is_last  = (idx_reg == head_job.last_idx);
    assign is_check = (idx_reg >= head_job.last_idx - 1'b1);
    assign head_pop = advance && is_last;
    assign pay_idx  = idx_reg - IDX_PAYLOAD;
    assign sum_upd  = sum_reg + cur_byte;

    always_comb begin
        case (pay_idx[3:1])
            3'd0:    cur_value = head_job.values[0];
            3'd1:    cur_value = head_job.values[1];
            3'd2:    cur_value = head_job.values[2];
            3'd3:    cur_value = head_job.values[3];
            3'd4:    cur_value = head_job.values[4];
            3'd5:    cur_value = head_job.values[5];
            default: cur_value = '0;
        endcase
        payload_byte = pay_idx[0] ? cur_value[15:8] : cur_value[7:0];
    end

    always_comb begin
        if (idx_reg == IDX_HDR) begin
            cur_byte = HDR_BYTE;
        end else if (idx_reg == IDX_DEST) begin
            cur_byte = dest_addr;
        end else if (idx_reg == IDX_FUNC) begin
            cur_byte = head_job.func_code;
        end else if (idx_reg == IDX_LEN) begin
            cur_byte = head_job.len_code;
        end else if (is_last) begin
            cur_byte = add_reg;
        end else if (idx_reg == head_job.last_idx - 1'b1) begin
            cur_byte = sum_reg;
        end else if (idx_reg == head_job.last_idx - 5'd2) begin
            cur_byte = STATUS_BYTE;
        end else begin
            cur_byte = payload_byte;
        end
    end

    always_comb begin
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        add_next     = add_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next          = 1'b1;
            m_data_next.out_byte  = cur_byte;
            m_data_next.last_byte = is_last;
            if (is_last) begin
                idx_next = '0;
                sum_next = '0;
                add_next = '0;
            end else begin
                idx_next = idx_reg + 1'b1;
                if (!is_check) begin
                    sum_next = sum_upd;
                    add_next = add_reg + sum_upd;
                end
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            sum_reg     <= '0;
            add_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            sum_reg     <= sum_next;
            add_reg     <= add_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `TFP_ASSERT(a_pop_loads_last, aclk, aresetn, head_pop |=> (m_valid && m_data.last_byte))
    `TFP_ASSERT_NEVER(a_idx_in_frame, aclk, aresetn, head_valid && (idx_reg > head_job.last_idx))
    `TFP_ASSERT(a_frame_restarts, aclk, aresetn, head_pop |=> (idx_reg == '0 && sum_reg == '0))

endmodule

>>> rtl/telemetry_frame_packer_core.sv
// Telemetry frame packer.
// A request on the s_ channel names a frame type and carries six 16-bit
// values; the block answers with the whole frame on the m_ channel, one byte
// per transfer, in transmission order, with last_byte set on the final add
// check byte. Frames are 19, 13 or 15 bytes long for six axes, three angles
// and quaternion requests; a request with an undefined frame type is taken
// and produces nothing.
// The first byte passes through the request queue and the output byte register.
// While the receiver is ready, the output byte register emits one byte per
// cycle, and frames queued behind each other follow without a gap.
// A short request queue sits in front of the serialiser, so requests are
// taken while a frame is still going out, until the queue is full.
// The destination address is written on the cfg_ channel, always ready, and
// should only be changed while no frame is pending.
// When the receiver stalls, the current byte holds and the serialiser waits.
// Reset clears the queue and the serialiser and sets the address to 0xFF.
module telemetry_frame_packer_core import tfp_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  tfp_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output tfp_out_t   m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic [7:0] dest_addr_reg;
    logic       head_valid;
    tfp_job_t   head_job;
    logic       head_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_addr_reg <= DEST_RESET;
        end else if (cfg_valid && cfg_ready) begin
            dest_addr_reg <= cfg_data;
        end
    end

    tfp_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .head_valid (head_valid),
        .head_job   (head_job),
        .head_pop   (head_pop)
    );

    tfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dest_addr  (dest_addr_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .head_pop   (head_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

>>> tb/telemetry_frame_packer_core_test.sv
module telemetry_frame_packer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tfp_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SETTLE_CYCLES    = 12;
    localparam int RANDOM_PER_PHASE = 76;
    localparam int NUM_PHASES       = 5;
    localparam int MAX_PRINTED      = 30;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    tfp_in_t    s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    tfp_out_t   m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    tfp_in_t    frame_reqs[$];
    tfp_out_t   expected_bytes[$];
    logic [7:0] dest_model = DEST_RESET;

    int   idle_pct      = 0;
    int   send_gap      = 0;
    int   ready_hold    = 0;
    logic s_taken       = 1'b0;
    int   reqs_issued   = 0;
    int   reqs_taken    = 0;
    int   hush_cycles   = 0;
    int   error_count   = 0;
    int   bytes_checked = 0;
    int   cfg_writes    = 0;
    int   frame_count[4] = '{default: 0};

    telemetry_frame_packer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTED) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        error_count++;
    endtask

    function automatic void queue_frame_bytes(input tfp_in_t req);
        logic [7:0]  seq[$];
        logic [15:0] vals[6];
        int          n_vals = 0;
        logic [7:0]  sum    = '0;
        logic [7:0]  add    = '0;
        vals = '{req.value_a, req.value_b, req.value_c,
                 req.value_d, req.value_e, req.value_f};
        case (req.cmd)
            CMD_SIX_AXES: begin
                seq = '{HDR_BYTE, dest_model, FUNC_SIX_AXES, LEN_SIX_AXES};
                n_vals = 6;
            end
            CMD_ANGLES: begin
                seq = '{HDR_BYTE, dest_model, FUNC_ANGLES, LEN_ANGLES};
                n_vals = 3;
            end
            CMD_QUAT: begin
                seq = '{HDR_BYTE, dest_model, FUNC_QUAT, LEN_QUAT};
                n_vals = 4;
            end
            default: begin
                return;
            end
        endcase
        for (int i = 0; i < n_vals; i++) begin
            seq.push_back(vals[i][7:0]);
            seq.push_back(vals[i][15:8]);
        end
        seq.push_back(STATUS_BYTE);
        foreach (seq[i]) begin
            sum += seq[i];
            add += sum;
        end
        seq.push_back(sum);
        seq.push_back(add);
        foreach (seq[i]) begin
            expected_bytes.push_back(tfp_out_t'{out_byte: seq[i],
                                                last_byte: (i == seq.size() - 1)});
        end
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_request(input tfp_in_t req);
        frame_reqs.push_back(req);
        reqs_issued++;
    endtask

    task automatic drain_and_settle();
        do @(negedge aclk);
        while (reqs_taken != reqs_issued || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_taken) begin
            if (send_gap > 0) begin
                s_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (frame_reqs.size() == 0) begin
                s_valid <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
                s_valid  <= 1'b0;
                send_gap <= $urandom_range(3);
            end else begin
                s_valid <= 1'b1;
                s_data  <= frame_reqs.pop_front();
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : monitor
        tfp_out_t want;
        if (!aresetn) begin
            s_taken     <= 1'b0;
            hush_cycles <= 0;
            dest_model = DEST_RESET;
        end else begin
            s_taken <= s_valid && s_ready;
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                hush_cycles <= 0;
            end else begin
                hush_cycles <= hush_cycles + 1;
            end
            if (cfg_valid && cfg_ready) begin
                dest_model = cfg_data;
                cfg_writes++;
            end
            if (s_valid && s_ready) begin
                queue_frame_bytes(s_data);
                frame_count[s_data.cmd]++;
                reqs_taken++;
            end
            if (m_valid && m_ready) begin
                bytes_checked++;
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("byte %02h arrived with no frame pending",
                                              m_data.out_byte));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  m_data.out_byte, want.out_byte));
                    end
                    if (m_data.last_byte !== want.last_byte) begin
                        report_mismatch($sformatf("last_byte %b, expected %b (byte %02h)",
                                                  m_data.last_byte, want.last_byte,
                                                  want.out_byte));
                    end
                end
            end
        end
    end

    initial begin : watchdog
        wait (aresetn);
        while (hush_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("Timed out: no request moved on any channel for %0d cycles.", WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        tfp_in_t    req;
        logic [7:0] dest_plan[NUM_PHASES];
        int         idle_plan[NUM_PHASES];
        dest_plan = '{8'h00, 8'h80, 8'($urandom), 8'hFF, 8'h01};
        idle_plan = '{25, 0, 50, 15, 0};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed requests run with the address still at its reset value.
        idle_pct = 25;
        push_request(tfp_in_t'{CMD_SIX_AXES, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 16'h0000, 16'h0000});
        push_request(tfp_in_t'{CMD_SIX_AXES, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'hFFFF, 16'hFFFF});
        push_request(tfp_in_t'{CMD_SIX_AXES, 16'h5555, 16'hAAAA, 16'h5555,
                               16'hAAAA, 16'h5555, 16'hAAAA});
        push_request(tfp_in_t'{CMD_SIX_AXES, 16'h00FF, 16'hFF00, 16'h0001,
                               16'h8000, 16'h7FFF, 16'hFFFE});
        push_request(tfp_in_t'{CMD_ANGLES, 16'h1234, 16'hFFFF, 16'h0001,
                               16'hFFFF, 16'hFFFF, 16'hFFFF});
        push_request(tfp_in_t'{CMD_ANGLES, 16'h0000, 16'h0000, 16'h0000,
                               16'hA5A5, 16'h5A5A, 16'hC3C3});
        push_request(tfp_in_t'{CMD_QUAT, 16'h8000, 16'h7FFF, 16'hFFFF,
                               16'h0000, 16'hDEAD, 16'hBEEF});
        push_request(tfp_in_t'{CMD_QUAT, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'h0000, 16'h0000});
        push_request(tfp_in_t'{CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'hFFFF, 16'hFFFF});
        push_request(tfp_in_t'{CMD_SIX_AXES, 16'h0102, 16'h0304, 16'h0506,
                               16'h0708, 16'h090A, 16'h0B0C});
        push_request(tfp_in_t'{CMD_NONE, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 16'h0000, 16'h0000});
        push_request(tfp_in_t'{CMD_ANGLES, 16'hFF00, 16'h00FF, 16'h8001,
                               16'h0000, 16'h0000, 16'h0000});
        push_request(tfp_in_t'{CMD_QUAT, 16'h0001, 16'h0002, 16'h0004,
                               16'h0008, 16'hFFFF, 16'hFFFF});
        drain_and_settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            @(negedge aclk);
            cfg_data  <= dest_plan[p];
            cfg_valid <= 1'b1;
            do @(posedge aclk);
            while (!cfg_ready);
            @(negedge aclk);
            cfg_valid <= 1'b0;
            idle_pct = idle_plan[p];

            // A small share of undefined frame types is mixed into each phase.
            repeat (RANDOM_PER_PHASE) begin
                req.cmd     = ($urandom_range(99) < 8) ? CMD_NONE : 2'($urandom_range(2));
                req.value_a = pick_value();
                req.value_b = pick_value();
                req.value_c = pick_value();
                req.value_d = pick_value();
                req.value_e = pick_value();
                req.value_f = pick_value();
                push_request(req);
            end
            drain_and_settle();
        end

        if (expected_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d expected bytes never arrived",
                                      expected_bytes.size()));
        end

        $display("Run covered %0d six-axis, %0d angle and %0d quaternion frames plus %0d undefined requests,",
                 frame_count[CMD_SIX_AXES], frame_count[CMD_ANGLES],
                 frame_count[CMD_QUAT], frame_count[CMD_NONE]);
        $display("with %0d bytes checked over %0d address settings and %0d mismatches.",
                 bytes_checked, cfg_writes + 1, error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
